// ----- design/twma_pkg.sv -----
`default_nettype none
package twma_pkg;

    localparam int DEPTH       = 128;
    localparam int PTR_W       = 7;
    localparam int CNT_W       = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_W      = 32;
    localparam int SUM_W       = 23;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd5000;

    typedef struct packed {
        logic [TIME_W-1:0]             sample_time;
        logic signed [SAMPLE_BITS-1:0] sample_value;
    } t_item;

    // request to the serial divider
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
        logic             neg;
    } t_div_req;

endpackage
`default_nettype wire

// ----- design/twma_front.sv -----
`default_nettype none
module twma_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire [31:0]           i_sample_time,
    input  wire signed [15:0]    i_sample_value,
    output logic                 o_avail,
    output twma_pkg::t_item      o_item,
    input  wire                  i_pop
);
    import twma_pkg::*;

    // two-deep request queue between the port and the window logic
    t_item      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{sample_time: i_sample_time, sample_value: i_sample_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- design/twma_div.sv -----
`default_nettype none
module twma_div (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  twma_pkg::t_div_req      i_req,
    output logic                    o_done,
    output logic signed [15:0]      o_quotient
);
    import twma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy, r_done, r_neg;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem, r_div;
    logic [CNT_W-1:0]  rem_sh;
    logic              fits;
    logic [SUM_W-1:0]  q_signed;

    // restoring division, one quotient bit a cycle, magnitude only
    assign rem_sh = {r_rem[CNT_W-2:0], r_quo[SUM_W-1]};
    assign fits   = (rem_sh >= r_div);

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= fits ? CNT_W'(rem_sh - r_div) : rem_sh;
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    assign q_signed   = r_neg ? SUM_W'(-r_quo) : r_quo;
    assign o_quotient = q_signed[SAMPLE_BITS-1:0];
    assign o_done     = r_done;

endmodule
`default_nettype wire

// ----- design/twma_back.sv -----
`default_nettype none
module twma_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_valid,
    input  wire [31:0]              i_cfg_window_ms,
    input  wire                     i_avail,
    input  twma_pkg::t_item         i_item,
    output logic                    o_pop,
    output twma_pkg::t_div_req      o_div_req,
    input  wire                     i_div_done,
    input  wire signed [15:0]       i_quotient,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic signed [15:0]      o_window_mean,
    output logic [7:0]              o_window_count,
    output logic                    o_overflow_drop
);
    import twma_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FULL  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    t_item              r_store [DEPTH];
    t_item              r_rd_entry;
    logic [2:0]         r_state, n_state;
    logic [PTR_W-1:0]   r_head, r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [TIME_W-1:0]  r_window, r_now;
    logic [SAMPLE_BITS-1:0] r_val;
    logic               r_drop;
    logic               r_out_valid;
    logic [TIME_W-1:0]  age;
    logic               evict;
    logic               do_write;
    logic               load_out;
    logic [SUM_W-1:0]   val_ext, old_ext;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign val_ext  = {{(SUM_W-SAMPLE_BITS){r_val[SAMPLE_BITS-1]}}, r_val};
    assign old_ext  = {{(SUM_W-SAMPLE_BITS){r_rd_entry.sample_value[SAMPLE_BITS-1]}},
                       r_rd_entry.sample_value};
    assign age      = r_now - r_rd_entry.sample_time;
    assign evict    = (age > r_window);
    assign do_write = (r_state == S_WRITE);
    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign o_pop    = (r_state == S_IDLE) && i_avail;

    // store: one write port at the tail, registered read at the head
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_store[r_tail] <= '{sample_time: r_now, sample_value: r_val};
        end
        r_rd_entry <= r_store[r_head];
    end

    always_comb begin
        o_div_req.start    = (r_state == S_CHK) && !evict;
        o_div_req.neg      = r_sum[SUM_W-1];
        o_div_req.dividend = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
        o_div_req.divisor  = r_count;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    n_state = (r_count == CNT_W'(DEPTH)) ? S_FULL : S_WRITE;
                end
            end
            S_FULL:  n_state = S_WRITE;
            S_WRITE: n_state = S_RD;
            S_RD:    n_state = S_CHK;
            S_CHK:   n_state = evict ? S_RD : S_DIV;
            S_DIV: begin
                if (i_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_now <= i_item.sample_time;
            r_val <= i_item.sample_value;
        end
        if (load_out) begin
            o_window_mean   <= i_quotient;
            o_window_count  <= r_count;
            o_overflow_drop <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_drop      <= 1'b0;
            r_window    <= WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_window <= i_cfg_window_ms;
            end
            if (o_pop) begin
                r_drop <= 1'b0;
            end
            // full store: the oldest entry goes before the write
            if (r_state == S_FULL) begin
                r_sum   <= r_sum - old_ext;
                r_head  <= next_ptr(r_head);
                r_count <= r_count - CNT_W'(1);
                r_drop  <= 1'b1;
            end
            if (do_write) begin
                r_sum   <= r_sum + val_ext;
                r_tail  <= next_ptr(r_tail);
                r_count <= r_count + CNT_W'(1);
            end
            if ((r_state == S_CHK) && evict) begin
                r_sum   <= r_sum - old_ext;
                r_head  <= next_ptr(r_head);
                r_count <= r_count - CNT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("window count above store depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_tail - r_head) == r_count[PTR_W-1:0])
        else $error("head/tail out of step with count");

    a_div_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> r_count != '0)
        else $error("divide started on empty window");

    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> $past(r_state) == S_OUT || $past(i_div_done))
        else $error("result state entered without divider completion");
`endif

endmodule
`default_nettype wire

// ----- design/time_window_moving_average.sv -----
// Flow: a request is popped from the input queue; when the store is full
//   the oldest entry goes first, then the write, then head entries older
//   than the window are evicted before the 23-step serial divider runs.
// Pace: the next request is popped only once the result is loaded; the
//   eviction walk over the single store read port and the divider set it.
// Reset: synchronous, active low; empties the window and sets window_ms to 5000.
`default_nettype none
module time_window_moving_average (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [31:0]         i_cfg_window_ms,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire [31:0]         i_sample_time,
    input  wire signed [15:0]  i_sample_value,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [15:0] o_window_mean,
    output logic [7:0]         o_window_count,
    output logic               o_overflow_drop
);
    import twma_pkg::*;

    logic               q_avail;
    t_item              q_item;
    logic               q_pop;
    t_div_req           div_req;
    logic               div_done;
    logic signed [15:0] div_quo;

    assign o_cfg_ready = 1'b1;

    twma_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .o_avail        (q_avail),
        .o_item         (q_item),
        .i_pop          (q_pop)
    );

    twma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    twma_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_window_ms (i_cfg_window_ms),
        .i_avail         (q_avail),
        .i_item          (q_item),
        .o_pop           (q_pop),
        .o_div_req       (div_req),
        .i_div_done      (div_done),
        .i_quotient      (div_quo),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_window_mean   (o_window_mean),
        .o_window_count  (o_window_count),
        .o_overflow_drop (o_overflow_drop)
    );

endmodule
`default_nettype wire
